/* hw/rtl/fbpa_pkg.sv */
// Shared definitions for the fixed block pool allocator.
// Holds field widths, register indexes, status codes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 16;
	localparam int BCNT_W    = 11;
	localparam int OIDX_W    = 10;
	localparam int OUSE_W    = 11;
	localparam int ST_W      = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam int DEF_NUM_BLOCKS = 1024;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BSIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BCOUNT = 2'd2;

	// Request kinds.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_SIZE  = 3'd2;
	localparam logic [ST_W-1:0] ST_BAD_ADDR  = 3'd3;
	localparam logic [ST_W-1:0] ST_NONE_USED = 3'd4;

	typedef struct packed {
		logic            clr_wr;
		logic            in_take;
		logic            mul_span;
		logic            mul_en;
		logic            link_rd;
		logic            div_start;
		logic            div_step;
		logic            commit_alloc;
		logic            commit_free;
		logic            out_load;
		logic [ST_W-1:0] out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic exhausted;
		logic bad_size;
		logic none_used;
		logic bsize_zero;
		logic off_ge_span;
		logic div_last;
		logic rem_nonzero;
		logic slot_free;
	} dp_stat_t;

endpackage

/* hw/rtl/fbpa_if.sv */
// Handshake channels of the fixed block pool allocator: request and result.
// Depends on fbpa_pkg for the field widths.
`timescale 1ns / 1ps

interface fbpa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [fbpa_pkg::SIZE_W-1:0]   request_size;
	logic [fbpa_pkg::ADDR_W-1:0]   free_address;

	modport source (output valid, output cmd, output request_size, output free_address,
		input ready);
	modport sink (input valid, input cmd, input request_size, input free_address,
		output ready);
endinterface

interface fbpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fbpa_pkg::ST_W-1:0]     status;
	logic [fbpa_pkg::ADDR_W-1:0]   block_address;
	logic [fbpa_pkg::OIDX_W-1:0]   slot_index;
	logic [fbpa_pkg::OUSE_W-1:0]   blocks_in_use;

	modport source (output valid, output status, output block_address, output slot_index,
		output blocks_in_use, input ready);
	modport sink (input valid, input status, input block_address, input slot_index,
		input blocks_in_use, output ready);
endinterface

/* hw/rtl/fbpa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/fbpa_ctrl.sv */
// Controller of the fixed block pool allocator: sequences the link-store clearing
// pass, request checks, the divider and the result hand-off. Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fbpa_pkg::dp_stat_t stat,
	output fbpa_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_SPAN   = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_DIVCHK = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0]                state_q, state_d;
	logic [fbpa_pkg::ST_W-1:0] st_q, st_d;
	logic                      ok_q;

	assign in_ready = (state_q == S_IDLE);
	assign ok_q     = (st_q == fbpa_pkg::ST_OK);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.out_status = st_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_take = in_valid;
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.is_free) begin
					state_d = S_FINISH;
					if (stat.exhausted) begin
						st_d = fbpa_pkg::ST_EXHAUSTED;
					end else if (stat.bad_size) begin
						st_d = fbpa_pkg::ST_BAD_SIZE;
					end else begin
						// Product and next link are both ready in the finishing cycle.
						st_d         = fbpa_pkg::ST_OK;
						cmd.mul_en   = 1'b1;
						cmd.link_rd  = 1'b1;
					end
				end else begin
					if (stat.none_used) begin
						st_d    = fbpa_pkg::ST_NONE_USED;
						state_d = S_FINISH;
					end else if (stat.bsize_zero) begin
						st_d    = fbpa_pkg::ST_BAD_ADDR;
						state_d = S_FINISH;
					end else begin
						cmd.mul_en   = 1'b1;
						cmd.mul_span = 1'b1;
						state_d      = S_SPAN;
					end
				end
			end
			S_SPAN: begin
				if (stat.off_ge_span) begin
					st_d    = fbpa_pkg::ST_BAD_ADDR;
					state_d = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_DIVCHK;
				end
			end
			S_DIVCHK: begin
				st_d    = stat.rem_nonzero ? fbpa_pkg::ST_BAD_ADDR : fbpa_pkg::ST_OK;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				// Wait here until the result register can take the item.
				if (stat.slot_free) begin
					cmd.out_load     = 1'b1;
					cmd.commit_alloc = ok_q && !stat.is_free;
					cmd.commit_free  = ok_q && stat.is_free;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			st_q    <= fbpa_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

/* hw/rtl/fbpa_dp.sv */
// Datapath of the fixed block pool allocator: configuration registers, free-list
// head, in-use count, link store, multiplier, restoring divider and result register.
// Depends on fbpa_pkg and fbpa_ram.
`timescale 1ns / 1ps

module fbpa_dp #(
	parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::CFG_DAT_W-1:0] cfg_wdata,
	input  logic                           in_cmd,
	input  logic [fbpa_pkg::SIZE_W-1:0]    in_request_size,
	input  logic [fbpa_pkg::ADDR_W-1:0]    in_free_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fbpa_pkg::ST_W-1:0]      out_status,
	output logic [fbpa_pkg::ADDR_W-1:0]    out_block_address,
	output logic [fbpa_pkg::OIDX_W-1:0]    out_slot_index,
	output logic [fbpa_pkg::OUSE_W-1:0]    out_blocks_in_use,
	input  fbpa_pkg::dp_cmd_t              cmd,
	output fbpa_pkg::dp_stat_t             stat
);

	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int LNK_W  = $clog2(NUM_BLOCKS + 1);
	localparam int CW     = (LNK_W > fbpa_pkg::BCNT_W) ? LNK_W : fbpa_pkg::BCNT_W;
	localparam int PROD_W = fbpa_pkg::SIZE_W + CW;
	localparam int CMP_W  = (PROD_W > fbpa_pkg::ADDR_W) ? PROD_W : fbpa_pkg::ADDR_W;
	localparam int DCNT_W = $clog2(IDX_W + 1);
	localparam int SW     = fbpa_pkg::SIZE_W;

	// Configuration.
	logic [fbpa_pkg::ADDR_W-1:0] base_q;
	logic [SW-1:0]               bsize_q;
	logic [fbpa_pkg::BCNT_W-1:0] bcount_q;

	// Allocator state.
	logic [LNK_W-1:0] head_q;
	logic [LNK_W-1:0] used_q;
	logic [LNK_W-1:0] used_d;
	logic [IDX_W-1:0] clr_q;

	// Latched request.
	logic                        is_free_q;
	logic [SW-1:0]               req_size_q;
	logic [fbpa_pkg::ADDR_W-1:0] off_q;

	logic [PROD_W-1:0] prod_q;
	logic [SW-1:0]     rem_q;
	logic [IDX_W-1:0]  sh_q;
	logic [IDX_W-1:0]  quo_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic              valid_q;
	logic [fbpa_pkg::ST_W-1:0]   status_q;
	logic [fbpa_pkg::ADDR_W-1:0] addr_q;
	logic [fbpa_pkg::OIDX_W-1:0] index_q;
	logic [fbpa_pkg::OUSE_W-1:0] inuse_q;

	logic [CW-1:0]    count;
	logic [CW-1:0]    mul_a;
	logic [SW+1:0]    trial;
	logic [LNK_W-1:0] link_rdata;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [LNK_W-1:0] ram_wdata;
	logic             out_ok;

	// Pool size in use is the configured count limited to the store depth.
	assign count = (CW'(bcount_q) > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(bcount_q);
	assign mul_a = cmd.mul_span ? count : CW'(head_q);

	// One restoring division step: bring down the next offset bit and try a subtract.
	assign trial = {1'b0, rem_q, sh_q[IDX_W-1]} - {2'b00, bsize_q};

	assign ram_we    = cmd.clr_wr || cmd.commit_free;
	assign ram_waddr = cmd.clr_wr ? clr_q : quo_q;
	assign ram_wdata = cmd.clr_wr ? (LNK_W'(clr_q) + LNK_W'(1)) : head_q;

	fbpa_ram #(
		.WIDTH (LNK_W),
		.DEPTH (NUM_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.link_rd),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (link_rdata)
	);

	always_comb begin
		used_d = used_q;
		if (cmd.commit_alloc && (used_q < LNK_W'(NUM_BLOCKS))) begin
			used_d = used_q + LNK_W'(1);
		end else if (cmd.commit_free) begin
			used_d = used_q - LNK_W'(1);
		end
	end

	assign out_ok = (cmd.out_status == fbpa_pkg::ST_OK);

	assign stat.clr_last    = (clr_q == IDX_W'(NUM_BLOCKS - 1));
	assign stat.is_free     = is_free_q;
	assign stat.exhausted   = (CW'(head_q) >= count);
	assign stat.bad_size    = (req_size_q == '0) || (req_size_q > bsize_q);
	assign stat.none_used   = (used_q == '0);
	assign stat.bsize_zero  = (bsize_q == '0);
	assign stat.off_ge_span = (CMP_W'(off_q) >= CMP_W'(prod_q));
	assign stat.div_last    = (dcnt_q == DCNT_W'(IDX_W - 1));
	assign stat.rem_nonzero = (rem_q != '0);
	assign stat.slot_free   = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			bsize_q  <= SW'(4);
			bcount_q <= fbpa_pkg::BCNT_W'(1024);
			head_q   <= '0;
			used_q   <= '0;
			clr_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fbpa_pkg::REG_BASE:   base_q   <= cfg_wdata;
					fbpa_pkg::REG_BSIZE:  bsize_q  <= cfg_wdata[SW-1:0];
					fbpa_pkg::REG_BCOUNT: bcount_q <= cfg_wdata[fbpa_pkg::BCNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.commit_alloc) begin
				head_q <= link_rdata;
			end else if (cmd.commit_free) begin
				head_q <= LNK_W'(quo_q);
			end
			used_q <= used_d;
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			is_free_q  <= (in_cmd == fbpa_pkg::CMD_FREE);
			req_size_q <= in_request_size;
			off_q      <= in_free_address - base_q;
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a * bsize_q);
		end
		if (cmd.div_start) begin
			// The offset is below the span, so its high part is already below the block size.
			rem_q  <= SW'(off_q >> IDX_W);
			sh_q   <= off_q[IDX_W-1:0];
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[SW+1]) begin
				rem_q <= trial[SW-1:0];
			end else begin
				rem_q <= {rem_q[SW-2:0], sh_q[IDX_W-1]};
			end
			sh_q   <= sh_q << 1;
			quo_q  <= IDX_W'({quo_q, !trial[SW+1]});
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			inuse_q  <= fbpa_pkg::OUSE_W'(used_d);
			if (out_ok && !is_free_q) begin
				addr_q  <= base_q + fbpa_pkg::ADDR_W'(prod_q);
				index_q <= fbpa_pkg::OIDX_W'(head_q);
			end else if (out_ok) begin
				addr_q  <= '0;
				index_q <= fbpa_pkg::OIDX_W'(quo_q);
			end else begin
				addr_q  <= '0;
				index_q <= '0;
			end
		end
	end

	assign out_valid         = valid_q;
	assign out_status        = status_q;
	assign out_block_address = addr_q;
	assign out_slot_index    = index_q;
	assign out_blocks_in_use = inuse_q;

endmodule

/* hw/rtl/fixed_block_pool_allocator_core.sv */
// Top level of the fixed block pool allocator: controller and datapath joined by
// command and status structs. Depends on fbpa_pkg, fbpa_if, fbpa_ctrl and fbpa_dp.
`timescale 1ns / 1ps

// Fixed-size block pool allocator. Each request item either allocates a block
// (popping the head of a linked free list of block indices) or frees one (the
// address is turned back into an index and pushed), and yields exactly one result
// item. After reset the link store is initialised by a clearing pass over all
// NUM_BLOCKS entries, during which no request is taken; configuration writes are
// accepted at any time. Requests are handled one at a time: an allocate passes the
// check and finish states before the next acceptance; a free that reaches the
// divider also passes the span check, the one-bit-per-cycle restoring divider that
// converts the offset into a block index, and the remainder check. Frees rejected
// early skip the divider. A finished result waits in the output register, and a
// further item is taken while it waits.
module fixed_block_pool_allocator_core #(
	parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::CFG_DAT_W-1:0] cfg_wdata,
	fbpa_req_if.sink                       req,
	fbpa_rsp_if.source                     rsp
);

	fbpa_pkg::dp_cmd_t  ctl_cmd;
	fbpa_pkg::dp_stat_t dp_stat;
	logic               in_ready;

	assign req.ready = in_ready;

	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	fbpa_dp #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_cmd            (req.cmd),
		.in_request_size   (req.request_size),
		.in_free_address   (req.free_address),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_status        (rsp.status),
		.out_block_address (rsp.block_address),
		.out_slot_index    (rsp.slot_index),
		.out_blocks_in_use (rsp.blocks_in_use),
		.cmd               (ctl_cmd),
		.stat              (dp_stat)
	);

endmodule

/* dv/testbench.sv */
// Self-checking testbench for fixed_block_pool_allocator_core: directed and random
// allocate/free items, checked against a free-list predictor kept in the testbench.
// Depends on fbpa_pkg, fbpa_if and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
	import fbpa_pkg::*;

	localparam int POOL_BLOCKS = DEF_NUM_BLOCKS;
	localparam int CYCLE_LIMIT = 250000;

	typedef struct packed {
		logic              cmd;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} pool_req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [ADDR_W-1:0] addr;
		logic [OIDX_W-1:0] index;
		logic [OUSE_W-1:0] in_use;
	} pool_rsp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	fbpa_req_if req_ch();
	fbpa_rsp_if rsp_ch();

	fixed_block_pool_allocator_core #(
		.NUM_BLOCKS(POOL_BLOCKS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow of the allocator state and registers.
	logic [BCNT_W-1:0] link_mem [POOL_BLOCKS];
	logic [BCNT_W-1:0] head_idx;
	logic [BCNT_W-1:0] used_blocks;
	logic [ADDR_W-1:0] cfg_base;
	logic [SIZE_W-1:0] cfg_bsize;
	logic [BCNT_W-1:0] cfg_bcount;

	pool_req_t   request_queue [$];
	pool_rsp_t   outcome_queue [$];
	int unsigned held_blocks [$];

	pool_req_t next_req;
	int        send_gap;
	int        hold_left;
	bit        long_hold_used;
	bit        want_long_hold = 1'b0;
	bit        quiet_tail = 1'b0;
	int        mismatch_count = 0;
	int        cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned usable_blocks();
		return (cfg_bcount < POOL_BLOCKS) ? cfg_bcount : POOL_BLOCKS;
	endfunction

	// Applies one request to the shadow state and returns the result it must give.
	function automatic pool_rsp_t allocator_outcome(input pool_req_t r);
		pool_rsp_t         o;
		int unsigned       pool;
		int unsigned       idx;
		logic [ADDR_W-1:0] off;
		longint unsigned   span;
		pool = usable_blocks();
		o = '0;
		o.status = ST_OK;
		if (r.cmd == CMD_ALLOC) begin
			if (head_idx >= pool) begin
				o.status = ST_EXHAUSTED;
			end else if (r.size == 0 || r.size > cfg_bsize) begin
				o.status = ST_BAD_SIZE;
			end else begin
				o.index = head_idx[OIDX_W-1:0];
				o.addr = cfg_base + ADDR_W'(head_idx) * ADDR_W'(cfg_bsize);
				held_blocks.push_back(head_idx);
				head_idx = link_mem[head_idx];
				if (used_blocks < POOL_BLOCKS)
					used_blocks = used_blocks + 1'b1;
			end
		end else begin
			if (used_blocks == 0) begin
				o.status = ST_NONE_USED;
			end else if (cfg_bsize == 0) begin
				o.status = ST_BAD_ADDR;
			end else begin
				off = r.addr - cfg_base;
				span = longint'(cfg_bsize) * pool;
				if (off >= span || off % cfg_bsize != 0) begin
					o.status = ST_BAD_ADDR;
				end else begin
					idx = off / cfg_bsize;
					if (idx < POOL_BLOCKS) begin
						link_mem[idx] = head_idx;
						head_idx = BCNT_W'(idx);
						used_blocks = used_blocks - 1'b1;
						o.index = OIDX_W'(idx);
					end else begin
						o.status = ST_BAD_ADDR;
					end
				end
			end
		end
		o.in_use = used_blocks;
		return o;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, actual %h", $time, what, want, got);
			mismatch_count++;
		end
	endfunction

	// Request driver: predicts each item as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= CMD_ALLOC;
			req_ch.request_size <= '0;
			req_ch.free_address <= '0;
			send_gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				outcome_queue.push_back(allocator_outcome({req_ch.cmd, req_ch.request_size,
					req_ch.free_address}));
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 3);
					req_ch.valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					next_req = request_queue.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.cmd <= next_req.cmd;
					req_ch.request_size <= next_req.size;
					req_ch.free_address <= next_req.addr;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
			long_hold_used <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (outcome_queue.size() == 0) begin
					$display("%0t: result item with none awaited, expected nothing, actual status %0d",
						$time, rsp_ch.status);
					mismatch_count++;
				end else begin
					pool_rsp_t want;
					want = outcome_queue.pop_front();
					check_field("status", want.status, rsp_ch.status);
					check_field("block_address", want.addr, rsp_ch.block_address);
					check_field("slot_index", want.index, rsp_ch.slot_index);
					check_field("blocks_in_use", want.in_use, rsp_ch.blocks_in_use);
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (want_long_hold && !long_hold_used) begin
				long_hold_used <= 1'b1;
				hold_left <= 299;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				hold_left <= $urandom_range(0, 3);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_request(input logic cmd, input int unsigned size,
		input logic [ADDR_W-1:0] addr);
		@(negedge clk);
		while (request_queue.size() >= 3)
			@(negedge clk);
		request_queue.push_back({cmd, SIZE_W'(size), addr});
	endtask

	task automatic wait_drained();
		while (request_queue.size() != 0 || req_ch.valid || outcome_queue.size() != 0)
			@(negedge clk);
	endtask

	// Registers change only with the block idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [31:0] value);
		wait_drained();
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= value;
		case (which)
			REG_BASE:   cfg_base = value;
			REG_BSIZE:  cfg_bsize = value[SIZE_W-1:0];
			REG_BCOUNT: cfg_bcount = value[BCNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [31:0] base, input int unsigned bsize,
		input int unsigned bcount);
		write_reg(REG_BASE, base);
		write_reg(REG_BSIZE, bsize);
		write_reg(REG_BCOUNT, bcount);
	endtask

	// Mostly allocations of legal size and frees of blocks known to be held; the rest
	// are out-of-range sizes, misaligned, out-of-pool and random addresses.
	task automatic run_mix(input int n, input int alloc_pct, input bit any_index);
		int unsigned       pool;
		int unsigned       bs;
		int unsigned       pick;
		int unsigned       sz;
		int unsigned       pos;
		logic [ADDR_W-1:0] addr;
		pool = usable_blocks();
		bs = cfg_bsize;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < alloc_pct) begin
				if ($urandom_range(0, 9) == 0)
					sz = $urandom_range(0, 65535);
				else
					sz = $urandom_range(1, bs);
				queue_request(CMD_ALLOC, sz, $urandom());
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 6 && held_blocks.size() != 0) begin
					pos = $urandom_range(0, held_blocks.size() - 1);
					addr = cfg_base + ADDR_W'(held_blocks[pos]) * ADDR_W'(bs);
					held_blocks.delete(pos);
				end else if (pick < 7 && any_index) begin
					addr = cfg_base + ADDR_W'($urandom_range(0, pool - 1)) * ADDR_W'(bs);
				end else if (pick < 8) begin
					addr = cfg_base + ADDR_W'(pool) * ADDR_W'(bs);
				end else if (pick < 9) begin
					addr = cfg_base + ADDR_W'($urandom_range(0, pool)) * ADDR_W'(bs)
						+ ADDR_W'($urandom_range(1, 3));
				end else begin
					addr = $urandom();
				end
				queue_request(CMD_FREE, $urandom_range(0, 65535), addr);
			end
		end
	endtask

	initial begin
		int unsigned victim;
		for (int i = 0; i < POOL_BLOCKS; i++)
			link_mem[i] = BCNT_W'(i + 1);
		head_idx = '0;
		used_blocks = '0;
		cfg_base = '0;
		cfg_bsize = 16'd4;
		cfg_bcount = BCNT_W'(POOL_BLOCKS);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: size checks, alignment and range of frees, empty pool.
		queue_request(CMD_FREE, 0, 32'd0);
		queue_request(CMD_ALLOC, 0, 32'd0);
		queue_request(CMD_ALLOC, 5, 32'd0);
		queue_request(CMD_ALLOC, 65535, 32'hFFFF_FFFF);
		queue_request(CMD_ALLOC, 1, 32'd0);
		queue_request(CMD_ALLOC, 4, 32'd0);
		queue_request(CMD_FREE, 0, 32'd2);
		queue_request(CMD_FREE, 0, 32'd4096);
		queue_request(CMD_FREE, 65535, 32'hFFFF_FFFF);
		queue_request(CMD_FREE, 0, 32'd4);
		queue_request(CMD_FREE, 0, 32'd0);
		queue_request(CMD_FREE, 0, 32'd0);

		// Top of the address space, largest block, single-block pool: addresses wrap.
		configure(32'hFFFF_FFFF, 65535, 1);
		queue_request(CMD_ALLOC, 65535, 32'd0);
		queue_request(CMD_ALLOC, 1, 32'd0);
		queue_request(CMD_FREE, 0, 32'h0000_FFFE);
		queue_request(CMD_FREE, 0, 32'hFFFF_FFFF);

		// Zero block size, zero block count and a count beyond the pool.
		configure(32'd0, 4, 2);
		queue_request(CMD_ALLOC, 4, 32'd0);
		write_reg(REG_BSIZE, 32'd0);
		queue_request(CMD_ALLOC, 1, 32'd0);
		queue_request(CMD_FREE, 0, 32'd0);
		write_reg(REG_BSIZE, 32'd4);
		write_reg(REG_BCOUNT, 32'd0);
		queue_request(CMD_ALLOC, 1, 32'd0);
		queue_request(CMD_FREE, 0, 32'd0);
		write_reg(REG_BCOUNT, 32'd1500);
		queue_request(CMD_FREE, 0, 32'd0);
		wait_drained();
		held_blocks.delete();

		configure($urandom(), 4, 16);
		run_mix(150, 60, 1'b0);

		// The receiver stalls for a long stretch at the start of this phase.
		configure(32'hFFFF_0000, 65535, POOL_BLOCKS);
		want_long_hold = 1'b1;
		run_mix(200, 70, 1'b0);

		configure($urandom(), $urandom_range(4, 65535), $urandom_range(2, 64));
		run_mix(200, 55, 1'b0);

		configure(32'd0, $urandom_range(4, 300), 1);
		run_mix(60, 50, 1'b0);

		configure($urandom(), $urandom_range(4, 65535), POOL_BLOCKS + $urandom_range(1, 1023));
		run_mix(100, 55, 1'b0);

		// A double free goes undetected; from here on the free list may hold a loop.
		quiet_tail = 1'b1;
		configure($urandom(), $urandom_range(4, 1000), POOL_BLOCKS);
		queue_request(CMD_ALLOC, 4, 32'd0);
		queue_request(CMD_ALLOC, 4, 32'd0);
		wait_drained();
		if (held_blocks.size() != 0) begin
			victim = held_blocks.pop_back();
			queue_request(CMD_FREE, 0, cfg_base + ADDR_W'(victim) * ADDR_W'(cfg_bsize));
			queue_request(CMD_FREE, 0, cfg_base + ADDR_W'(victim) * ADDR_W'(cfg_bsize));
		end
		run_mix(220, 55, 1'b1);

		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_if.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_dp.sv
hw/rtl/fixed_block_pool_allocator_core.sv
dv/testbench.sv
